// File: rtl/core/mtfb_pkg.sv
// mtfb_pkg: shared types and constants for the monochrome text framebuffer
// no dependencies

package mtfb_pkg;

   localparam int FRAME_BYTES = 1024;
   localparam int FRAME_AW    = 10;
   localparam int FIRST_CODE  = 32;

   localparam logic [2:0] OP_FILL   = 3'd0;
   localparam logic [2:0] OP_PIXEL  = 3'd1;
   localparam logic [2:0] OP_CHAR   = 3'd2;
   localparam logic [2:0] OP_CURSOR = 3'd3;
   localparam logic [2:0] OP_FONT   = 3'd4;
   localparam logic [2:0] OP_READ   = 3'd5;

   localparam logic [1:0] REG_GLYPH_WIDTH  = 2'd0;
   localparam logic [1:0] REG_GLYPH_HEIGHT = 2'd1;
   localparam logic [1:0] REG_INVERT       = 2'd2;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  pos_x;
      logic [7:0]  pos_y;
      logic        pixel_color;
      logic [7:0]  char_code;
      logic [11:0] font_addr;
      logic [15:0] font_value;
      logic [9:0]  byte_addr;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       char_accepted;
      logic [7:0] cursor_col;
   } rsp_type;

endpackage

// File: rtl/core/monochrome_text_framebuffer.sv
// monochrome_text_framebuffer: page-organized 1-bit framebuffer with glyph renderer
// depends on mtfb_pkg

// One request beat yields one response beat. Cursor, font load, rejected-char and
// unused ops pass from decode straight to the response step; a byte read first
// reads the frame memory and a pixel reads it and writes it back; fill sweeps the
// 1024-byte frame memory at one byte a cycle; an accepted glyph reads each font
// row, then does a read-modify-write per pixel through the shared pixel address.
// A response still waiting on rsp_ready holds off the next one. The frame memory
// is cleared by a pass after reset, during which req_ready is low.
module monochrome_text_framebuffer #(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 64,
   parameter int FONT_WORDS    = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mtfb_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mtfb_pkg::rsp_type    rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [3:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   localparam int FONT_AW = (FONT_WORDS > 1) ? $clog2(FONT_WORDS) : 1;
   localparam int FA = FONT_AW + 8;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_DEC   = 4'd2;
   localparam logic [3:0] S_FILL  = 4'd3;
   localparam logic [3:0] S_PRD   = 4'd4;
   localparam logic [3:0] S_PWAIT = 4'd5;
   localparam logic [3:0] S_PWR   = 4'd6;
   localparam logic [3:0] S_FRD   = 4'd7;
   localparam logic [3:0] S_FWAIT = 4'd8;
   localparam logic [3:0] S_BYTE  = 4'd9;
   localparam logic [3:0] S_RESP  = 4'd10;
   localparam logic [3:0] S_RDW   = 4'd11;
   localparam logic [3:0] S_RDD   = 4'd12;

   logic [7:0]  frame_mem [mtfb_pkg::FRAME_BYTES];
   logic [15:0] font_mem  [FONT_WORDS];

   logic [3:0]  state_ff, state_in;
   logic [4:0]  gw_ff;
   logic [5:0]  gh_ff;
   logic        inv_ff;
   logic [7:0]  ccol_ff, crow_ff, ccol_in, crow_in;
   mtfb_pkg::req_type req_ff;
   mtfb_pkg::rsp_type rsp_ff;
   logic        rsp_valid_ff;
   logic [10:0] cnt_ff, cnt_in;
   logic [5:0]  row_ff, row_in;
   logic [4:0]  col_ff, col_in;
   logic [FA-1:0] base_ff, base_in;
   logic [15:0] fword_ff;
   logic [7:0]  rdata_ff;
   logic [7:0]  px_x_ff, px_y_ff, px_x_in, px_y_in;
   logic        px_c_ff, px_c_in;
   logic        acc_in;

   // single shared pixel addressing unit
   logic [8:0]  sx, sy;
   logic        pix_ok;
   logic [15:0] pix_idx;
   logic [9:0]  pix_addr;
   logic [7:0]  pix_mask, pix_new;
   logic        pix_col;

   assign sx = {1'b0, px_x_ff};
   assign sy = {1'b0, px_y_ff};
   assign pix_idx = 16'(px_x_ff) + 16'(px_y_ff[7:3]) * 16'(SCREEN_WIDTH);
   assign pix_ok = (sx < 9'(SCREEN_WIDTH)) && (sy < 9'(SCREEN_HEIGHT))
                   && (pix_idx < 16'(mtfb_pkg::FRAME_BYTES));
   assign pix_addr = pix_idx[9:0];
   assign pix_mask = 8'(1) << px_y_ff[2:0];
   assign pix_col = px_c_ff ^ inv_ff;
   assign pix_new = pix_col ? (rdata_ff | pix_mask) : (rdata_ff & ~pix_mask);

   logic [9:0]  gsum_w, gsum_h;
   logic [FA-1:0] last_word;
   logic        char_ok;
   assign gsum_w = 10'(ccol_ff) + 10'(gw_ff);
   assign gsum_h = 10'(crow_ff) + 10'(gh_ff);
   assign last_word = base_ff + FA'(gh_ff) - FA'(1);
   assign char_ok = (req_ff.char_code >= 8'(mtfb_pkg::FIRST_CODE))
                    && (gsum_w < 10'(SCREEN_WIDTH)) && (gsum_h < 10'(SCREEN_HEIGHT))
                    && ((gh_ff == 6'd0) || (last_word < FA'(FONT_WORDS)));

   logic [FA-1:0] font_rd_addr;
   assign font_rd_addr = base_ff + FA'(row_ff);

   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR)
         frame_mem[cnt_ff[9:0]] <= 8'h00;
      else if (state_ff == S_FILL)
         frame_mem[cnt_ff[9:0]] <= {8{req_ff.pixel_color}};
      else if (state_ff == S_PWR && pix_ok)
         frame_mem[pix_addr] <= pix_new;
      if (state_ff == S_RDD)
         rdata_ff <= frame_mem[req_ff.byte_addr];
      else if (state_ff != S_RESP)
         rdata_ff <= frame_mem[pix_addr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DEC && req_ff.operation == mtfb_pkg::OP_FONT
          && 32'(req_ff.font_addr) < 32'(FONT_WORDS))
         font_mem[FONT_AW'(req_ff.font_addr)] <= req_ff.font_value;
      fword_ff <= font_mem[font_rd_addr[FONT_AW-1:0]];
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      row_in = row_ff;
      col_in = col_ff;
      base_in = base_ff;
      ccol_in = ccol_ff;
      crow_in = crow_ff;
      px_x_in = px_x_ff;
      px_y_in = px_y_ff;
      px_c_in = px_c_ff;
      acc_in = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cnt_in = cnt_ff + 11'd1;
            if (cnt_ff == 11'(mtfb_pkg::FRAME_BYTES - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DEC;
               base_in = FA'(req_data.char_code - 8'(mtfb_pkg::FIRST_CODE)) * FA'(gh_ff);
            end
         end
         S_DEC: begin
            cnt_in = '0;
            row_in = '0;
            col_in = '0;
            px_x_in = req_ff.pos_x;
            px_y_in = req_ff.pos_y;
            px_c_in = req_ff.pixel_color;
            state_in = S_RESP;
            case (req_ff.operation)
               mtfb_pkg::OP_FILL:   state_in = S_FILL;
               mtfb_pkg::OP_PIXEL:  state_in = S_PRD;
               mtfb_pkg::OP_CURSOR: begin
                  ccol_in = req_ff.pos_x;
                  crow_in = req_ff.pos_y;
               end
               mtfb_pkg::OP_READ:   state_in = S_RDW;
               mtfb_pkg::OP_CHAR: begin
                  if (char_ok) begin
                     state_in = (gh_ff == 6'd0 || gw_ff == 5'd0) ? S_BYTE : S_FRD;
                  end
               end
               default: state_in = S_RESP;
            endcase
         end
         S_FILL: begin
            cnt_in = cnt_ff + 11'd1;
            if (cnt_ff == 11'(mtfb_pkg::FRAME_BYTES - 1)) state_in = S_RESP;
         end
         S_PRD:   state_in = S_PWAIT;
         S_PWAIT: state_in = S_PWR;
         S_PWR: begin
            if (req_ff.operation == mtfb_pkg::OP_PIXEL) state_in = S_RESP;
            else if (col_ff == gw_ff - 5'd1) begin
               col_in = '0;
               if (row_ff == gh_ff - 6'd1) state_in = S_BYTE;
               else begin
                  row_in = row_ff + 6'd1;
                  state_in = S_FRD;
               end
            end else begin
               col_in = col_ff + 5'd1;
               state_in = S_FWAIT;
            end
         end
         S_FRD: state_in = S_FWAIT;
         S_FWAIT: begin
            px_x_in = ccol_ff + 8'(col_ff);
            px_y_in = crow_ff + 8'(row_ff);
            px_c_in = (col_ff[4] ? 1'b0 : fword_ff[4'd15 - col_ff[3:0]])
                      ? req_ff.pixel_color : ~req_ff.pixel_color;
            state_in = S_PRD;
         end
         S_BYTE: begin
            ccol_in = ccol_ff + 8'(gw_ff);
            acc_in = 1'b1;
            state_in = S_RESP;
         end
         S_RDW: state_in = S_RDD;
         S_RDD: state_in = S_RESP;
         S_RESP: if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   logic char_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff <= '0;
         gw_ff <= 5'd7;
         gh_ff <= 6'd10;
         inv_ff <= 1'b0;
         ccol_ff <= '0;
         crow_ff <= '0;
         rsp_valid_ff <= 1'b0;
         char_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         ccol_ff <= ccol_in;
         crow_ff <= crow_in;
         if (state_ff == S_DEC) char_ok_ff <= 1'b0;
         else if (acc_in) char_ok_ff <= 1'b1;
         if (psel && penable && pwrite) begin
            case (paddr[3:2])
               mtfb_pkg::REG_GLYPH_WIDTH:  gw_ff <= pwdata[4:0];
               mtfb_pkg::REG_GLYPH_HEIGHT: gh_ff <= pwdata[5:0];
               mtfb_pkg::REG_INVERT:       inv_ff <= pwdata[0];
               default: ;
            endcase
         end
         if (state_ff == S_RESP && state_in == S_IDLE) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
      col_ff <= col_in;
      base_ff <= base_in;
      px_x_ff <= px_x_in;
      px_y_ff <= px_y_in;
      px_c_ff <= px_c_in;
      if (state_ff == S_IDLE && req_valid) req_ff <= req_data;
      if (state_ff == S_RESP && state_in == S_IDLE) begin
         rsp_ff.read_data <= (req_ff.operation == mtfb_pkg::OP_READ) ? rdata_ff : 8'h00;
         rsp_ff.char_accepted <= char_ok_ff;
         rsp_ff.cursor_col <= ccol_ff;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign pready = 1'b1;

   always_comb begin
      prdata = '0;
      case (paddr[3:2])
         mtfb_pkg::REG_GLYPH_WIDTH:  prdata = 32'(gw_ff);
         mtfb_pkg::REG_GLYPH_HEIGHT: prdata = 32'(gh_ff);
         mtfb_pkg::REG_INVERT:       prdata = 32'(inv_ff);
         default: prdata = '0;
      endcase
   end

`ifndef NO_ASSERTIONS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_no_ready_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_ready) else $error("ready during clear");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)) else $error("rsp dropped");
   a_accept_byte: assert property (@(posedge clock) disable iff (reset)
      acc_in |-> state_ff == S_BYTE) else $error("accept outside byte step");
`endif

endmodule
